// ===== hw/rtl/ssmvc_pkg.sv =====
// Package for the still-sample mean/variance capture block.
// Holds command codes, register indexes, sequencer states and unit request types.
// No dependencies.
`default_nettype none

package ssmvc_pkg;

    localparam int DVD_W     = 48;  // divider dividend and quotient width
    localparam int DIV_LEN_W = 6;   // iteration count field of a divider request
    localparam int M2_W      = 48;
    localparam int LIM_W     = 16;  // configuration register width
    localparam int MEAN_OUT_W = 22;
    localparam int VAR_OUT_W  = 32;
    localparam int CNT_OUT_W  = 16;
    localparam int VAR_SHIFT  = 10;
    localparam int MAG_SHIFT  = 10;

    localparam logic [1:0] CMD_SAMPLE = 2'd0;
    localparam logic [1:0] CMD_BEGIN  = 2'd1;
    localparam logic [1:0] CMD_CANCEL = 2'd2;
    localparam logic [1:0] CMD_FINISH = 2'd3;

    localparam logic [2:0] FACE_LAST = 3'd5;
    localparam logic [2:0] FACE_IDLE = 3'd7;

    localparam logic [2:0] REG_MAX_GYRO  = 3'd0;
    localparam logic [2:0] REG_MIN_ACCEL = 3'd1;
    localparam logic [2:0] REG_MAX_ACCEL = 3'd2;
    localparam logic [2:0] REG_RUN_LIMIT = 3'd3;
    localparam logic [2:0] REG_REQUIRED  = 3'd4;

    typedef enum logic [3:0] {
        S_IDLE,
        S_DECODE,
        S_MUL,
        S_ACC,
        S_CHECK,
        S_ASTART,
        S_AWAIT,
        S_AMUL,
        S_AACC,
        S_MSTART,
        S_MWAIT,
        S_VSTART,
        S_VWAIT,
        S_OUT
    } t_state;

    typedef struct packed {
        logic                 start;
        logic [DIV_LEN_W-1:0] len;
    } t_div_req;

endpackage

`default_nettype wire

// ===== hw/rtl/ssmvc_div.sv =====
// Restoring unsigned divider, one quotient bit per cycle.
// Depends on ssmvc_pkg for the dividend width and the request struct.
`default_nettype none

module ssmvc_div #(
    parameter int DVS_W = 16
) (
    input  wire                            i_clk,
    input  wire                            i_rst_n,
    input  ssmvc_pkg::t_div_req            i_req,
    input  wire [ssmvc_pkg::DVD_W-1:0]     i_dividend,
    input  wire [DVS_W-1:0]                i_divisor,
    output logic                           o_done,
    output logic [ssmvc_pkg::DVD_W-1:0]    o_quot
);

    localparam int DW = ssmvc_pkg::DVD_W;

    logic                              r_busy;
    logic [ssmvc_pkg::DIV_LEN_W-1:0]   r_cnt;
    logic [DW-1:0]                     r_q;
    logic [DVS_W-1:0]                  r_rem;
    logic [DVS_W-1:0]                  r_dvs;
    logic                              r_done;
    logic [DVS_W:0]                    trial;
    logic                              fits;

    always_comb begin
        trial = {r_rem, r_q[DW-1]};
        fits  = trial >= {1'b0, r_dvs};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_cnt  <= i_req.len;
            end else if (r_busy) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == ssmvc_pkg::DIV_LEN_W'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // Align the dividend so its low len bits sit at the top and are consumed MSB first.
    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_q   <= i_dividend << (DW - int'(i_req.len));
            r_rem <= '0;
            r_dvs <= i_divisor;
        end else if (r_busy) begin
            r_q   <= {r_q[DW-2:0], fits};
            r_rem <= fits ? DVS_W'(trial - {1'b0, r_dvs}) : trial[DVS_W-1:0];
        end
    end

    assign o_done = r_done;
    assign o_quot = r_q;

endmodule

`default_nettype wire

// ===== hw/rtl/ssmvc_sqrt.sv =====
// Digit-by-digit integer square root, one root bit per cycle.
// No package dependencies.
`default_nettype none

module ssmvc_sqrt #(
    parameter int VW = 42
) (
    input  wire              i_clk,
    input  wire              i_rst_n,
    input  wire              i_start,
    input  wire [VW-1:0]     i_value,
    output logic             o_busy,
    output logic [VW/2-1:0]  o_root
);

    localparam int RW  = VW / 2;
    localparam int CW  = $clog2(RW + 1);

    logic            r_busy;
    logic [CW-1:0]   r_cnt;
    logic [VW-1:0]   r_val;
    logic [RW+1:0]   r_rem;
    logic [RW-1:0]   r_root;
    logic [RW+2:0]   shifted;
    logic [RW+2:0]   trial;
    logic            fits;

    always_comb begin
        shifted = {r_rem[RW:0], r_val[VW-1:VW-2]};
        trial   = {1'b0, r_root, 2'b01};
        fits    = shifted >= trial;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= '0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_cnt  <= CW'(RW);
        end else if (r_busy) begin
            r_cnt <= r_cnt - 1'b1;
            if (r_cnt == CW'(1)) begin
                r_busy <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_val  <= i_value;
            r_rem  <= '0;
            r_root <= '0;
        end else if (r_busy) begin
            r_val  <= {r_val[VW-3:0], 2'b00};
            r_rem  <= fits ? (RW+2)'(shifted - trial) : shifted[RW+1:0];
            r_root <= {r_root[RW-2:0], fits};
        end
    end

    assign o_busy = r_busy;
    assign o_root = r_root;

endmodule

`default_nettype wire

// ===== hw/rtl/still_sample_mean_variance_capture.sv =====
// Still-sample accelerometer capture for one calibration face.
// Stream in: s_axis_tuser carries the command, s_axis_tdata the face and the
// six IMU axes. Stream out: one transaction per input transaction with flags,
// running means, variances, mean magnitude and counters in m_axis_tdata.
// Configuration: write i_cfg_wdata to register i_cfg_index while i_cfg_wr_en
// is high; write only while no transaction is in flight.
// A sequencer drives one shared multiplier, one serial divider and a serial
// square root. An accepted sample runs the per-axis mean divisions and the
// magnitude mean division on the divider; a completed finish runs three 48-bit
// divisions of M2 by n-1.
// s_axis_tready is high only while the sequencer is idle; a new transaction
// may enter while the previous result still waits on m_axis_tready, and the
// sequencer holds before its output stage until the slot is free.
// Reset disarms the block, clears all accumulation and loads the register
// defaults; no output transaction is pending after reset.
`default_nettype none

module still_sample_mean_variance_capture #(
    parameter int SAMPLE_BITS = 16,
    parameter int COUNT_BITS  = 16
) (
    input  wire          i_clk,
    input  wire          i_rst_n,
    input  wire          i_cfg_wr_en,
    input  wire [2:0]    i_cfg_index,
    input  wire [15:0]   i_cfg_wdata,
    input  wire          s_axis_tvalid,
    output logic         s_axis_tready,
    // face[2:0] accel_x[18:3] accel_y[34:19] accel_z[50:35]
    // gyro_x[66:51] gyro_y[82:67] gyro_z[98:83], zero [103:99]
    input  wire [103:0]  s_axis_tdata,
    // cmd[1:0]
    input  wire [1:0]    s_axis_tuser,
    output logic         m_axis_tvalid,
    input  wire          m_axis_tready,
    // ok[0] capture_done[1] face_out[4:2] mean_x[26:5] mean_y[48:27]
    // mean_z[70:49] var_x[102:71] var_y[134:103] var_z[166:135]
    // mean_magnitude[188:167] accepted_count[204:189] rejected_count[220:205]
    // zero [223:221]
    output logic [223:0] m_axis_tdata
);

    localparam int SB    = SAMPLE_BITS;
    localparam int CB    = COUNT_BITS;
    localparam int MW    = SB + 5;              // axis mean, 2^-16 g
    localparam int DW    = SB + 6;              // deltas and multiplier operands
    localparam int PW    = 2 * DW;
    localparam int SQW   = 2 * SB;              // sum of three squares
    localparam int LW    = (SQW > 32) ? SQW : 32;
    localparam int VW    = SQW + ssmvc_pkg::MAG_SHIFT;
    localparam int RW    = VW / 2;              // magnitude root
    localparam int CMPW  = (CB > 16) ? CB : 16;
    localparam int SUMW  = ((PW > ssmvc_pkg::M2_W) ? PW : ssmvc_pkg::M2_W) + 1;
    localparam int DVD_W = ssmvc_pkg::DVD_W;
    localparam logic [ssmvc_pkg::DIV_LEN_W-1:0] MEAN_LEN =
        ssmvc_pkg::DIV_LEN_W'(SB + 5);
    localparam logic [ssmvc_pkg::DIV_LEN_W-1:0] VAR_LEN =
        ssmvc_pkg::DIV_LEN_W'(DVD_W);

    ssmvc_pkg::t_state r_state, n_state;

    logic [15:0] r_cfg_gyro, r_cfg_amin, r_cfg_amax, r_cfg_run, r_cfg_req;

    logic [1:0]           r_cmd;
    logic [2:0]           r_face_in;
    logic signed [SB-1:0] r_a [3];
    logic signed [SB-1:0] r_g [3];
    logic [3:0]           r_idx;
    logic [SQW-1:0]       r_asq, r_gsq;
    logic [31:0]          r_lg, r_lmin, r_lmax;
    logic signed [PW-1:0] r_prod;
    logic signed [DW-1:0] r_d;

    logic                 r_armed;
    logic [2:0]           r_armed_face;
    logic [CB-1:0]        r_accepted, r_rejected, r_run;
    logic signed [MW-1:0] r_mean [3];
    logic [ssmvc_pkg::M2_W-1:0] r_m2 [3];
    logic [RW-1:0]        r_magmean;
    logic                 r_ok;
    logic [31:0]          r_var [3];

    logic                 r_mvalid;
    logic [223:0]         r_mdata;

    logic                 s_acc;
    logic                 out_free;
    logic                 done_now;
    logic                 pass;
    logic [1:0]           ax;
    logic signed [DW-1:0] x_sel, mean_sel, d_now, op_a, op_b, q_s, diff_now;
    logic [DW-1:0]        d_abs;
    logic [SUMW-1:0]      m2_sum;
    logic [CB-1:0]        acc_inc, run_inc, rej_inc;
    logic                 run_clear;
    ssmvc_pkg::t_div_req  div_req;
    logic [DVD_W-1:0]     div_dvd;
    logic [CB-1:0]        div_dvs;
    logic                 div_done;
    logic [DVD_W-1:0]     div_q;
    logic                 sqrt_start;
    logic                 sqrt_busy;
    logic [RW-1:0]        sqrt_root;
    logic [63:0]          mx [3];
    logic [63:0]          mag64, acc64, rej64;
    logic [DW:0]          limit_ext;

    assign s_axis_tready = (r_state == ssmvc_pkg::S_IDLE);
    assign s_acc         = s_axis_tvalid && s_axis_tready;
    assign out_free      = !r_mvalid || m_axis_tready;
    assign done_now      = r_armed && (CMPW'(r_accepted) >= CMPW'(r_cfg_req));
    assign ax            = r_idx[1:0];

    always_comb begin
        x_sel    = DW'(signed'({r_a[ax], 5'b00000}));
        mean_sel = DW'(r_mean[ax]);
        d_now    = x_sel - mean_sel;
        diff_now = DW'({1'b0, sqrt_root}) - DW'({1'b0, r_magmean});
        d_abs    = r_d[DW-1] ? DW'(-r_d) : DW'(r_d);
        q_s      = DW'({1'b0, div_q[DW-2:0]});
        if (r_d[DW-1]) begin
            q_s = -q_s;
        end
        pass = (LW'(r_gsq) <= LW'(r_lg)) && (LW'(r_asq) >= LW'(r_lmin)) &&
               (LW'(r_asq) <= LW'(r_lmax));
        acc_inc = (r_accepted == '1) ? r_accepted : r_accepted + 1'b1;
        rej_inc = (r_rejected == '1) ? r_rejected : r_rejected + 1'b1;
        run_inc = (r_run == '1) ? r_run : r_run + 1'b1;
        run_clear = (r_cfg_run != 16'd0) && (r_accepted != '0) &&
                    (CMPW'(run_inc) >= CMPW'(r_cfg_run));
        m2_sum = SUMW'(r_m2[ax]) + SUMW'(unsigned'(r_prod));
    end

    // Operand select for the shared multiplier.
    always_comb begin
        op_a = '0;
        op_b = '0;
        limit_ext = '0;
        if (r_state == ssmvc_pkg::S_AMUL) begin
            op_a = r_d;
            op_b = d_now;
        end else if (r_idx < 4'd3) begin
            op_a = DW'(r_a[ax]);
            op_b = op_a;
        end else if (r_idx < 4'd6) begin
            op_a = DW'(r_g[2'(r_idx - 4'd3)]);
            op_b = op_a;
        end else begin
            case (r_idx)
                4'd6:    limit_ext = (DW+1)'(r_cfg_gyro);
                4'd7:    limit_ext = (DW+1)'(r_cfg_amin);
                default: limit_ext = (DW+1)'(r_cfg_amax);
            endcase
            op_a = signed'(limit_ext[DW-1:0]);
            op_b = op_a;
        end
    end

    always_comb begin
        n_state    = r_state;
        div_req    = '0;
        div_dvd    = DVD_W'(d_abs);
        div_dvs    = r_accepted;
        sqrt_start = 1'b0;
        case (r_state)
            ssmvc_pkg::S_IDLE: begin
                if (s_acc) n_state = ssmvc_pkg::S_DECODE;
            end
            ssmvc_pkg::S_DECODE: begin
                case (r_cmd)
                    ssmvc_pkg::CMD_SAMPLE:
                        n_state = r_armed ? ssmvc_pkg::S_MUL : ssmvc_pkg::S_OUT;
                    ssmvc_pkg::CMD_FINISH:
                        n_state = (done_now && r_accepted >= CB'(2)) ?
                                  ssmvc_pkg::S_VSTART : ssmvc_pkg::S_OUT;
                    default: n_state = ssmvc_pkg::S_OUT;
                endcase
            end
            ssmvc_pkg::S_MUL: n_state = ssmvc_pkg::S_ACC;
            ssmvc_pkg::S_ACC: begin
                n_state = (r_idx == 4'd8) ? ssmvc_pkg::S_CHECK : ssmvc_pkg::S_MUL;
            end
            ssmvc_pkg::S_CHECK: begin
                if (pass) begin
                    sqrt_start = 1'b1;
                    n_state    = ssmvc_pkg::S_ASTART;
                end else begin
                    n_state = ssmvc_pkg::S_OUT;
                end
            end
            ssmvc_pkg::S_ASTART: begin
                div_req.start = 1'b1;
                div_req.len   = MEAN_LEN;
                div_dvd       = DVD_W'(d_now[DW-1] ? DW'(-d_now) : DW'(d_now));
                n_state       = ssmvc_pkg::S_AWAIT;
            end
            ssmvc_pkg::S_AWAIT: begin
                if (div_done) n_state = ssmvc_pkg::S_AMUL;
            end
            ssmvc_pkg::S_AMUL: n_state = ssmvc_pkg::S_AACC;
            ssmvc_pkg::S_AACC: begin
                n_state = (r_idx == 4'd2) ? ssmvc_pkg::S_MSTART : ssmvc_pkg::S_ASTART;
            end
            ssmvc_pkg::S_MSTART: begin
                if (!sqrt_busy) begin
                    div_req.start = 1'b1;
                    div_req.len   = MEAN_LEN;
                    div_dvd       = DVD_W'(diff_now[DW-1] ? DW'(-diff_now) :
                                           DW'(diff_now));
                    n_state       = ssmvc_pkg::S_MWAIT;
                end
            end
            ssmvc_pkg::S_MWAIT: begin
                if (div_done) n_state = ssmvc_pkg::S_OUT;
            end
            ssmvc_pkg::S_VSTART: begin
                div_req.start = 1'b1;
                div_req.len   = VAR_LEN;
                div_dvd       = r_m2[ax];
                div_dvs       = r_accepted - 1'b1;
                n_state       = ssmvc_pkg::S_VWAIT;
            end
            ssmvc_pkg::S_VWAIT: begin
                if (div_done) begin
                    n_state = (r_idx == 4'd2) ? ssmvc_pkg::S_OUT : ssmvc_pkg::S_VSTART;
                end
            end
            ssmvc_pkg::S_OUT: begin
                if (out_free) n_state = ssmvc_pkg::S_IDLE;
            end
            default: n_state = ssmvc_pkg::S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ssmvc_pkg::S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg_gyro <= 16'd80;
            r_cfg_amin <= 16'd1843;
            r_cfg_amax <= 16'd2253;
            r_cfg_run  <= 16'd10;
            r_cfg_req  <= 16'd200;
        end else if (i_cfg_wr_en) begin
            case (i_cfg_index)
                ssmvc_pkg::REG_MAX_GYRO:  r_cfg_gyro <= i_cfg_wdata;
                ssmvc_pkg::REG_MIN_ACCEL: r_cfg_amin <= i_cfg_wdata;
                ssmvc_pkg::REG_MAX_ACCEL: r_cfg_amax <= i_cfg_wdata;
                ssmvc_pkg::REG_RUN_LIMIT: r_cfg_run  <= i_cfg_wdata;
                ssmvc_pkg::REG_REQUIRED:  r_cfg_req  <= i_cfg_wdata;
                default: ;
            endcase
        end
    end

    // Input capture and the multiplier register; payload, no reset.
    always_ff @(posedge i_clk) begin
        if (s_acc) begin
            r_cmd     <= s_axis_tuser;
            r_face_in <= s_axis_tdata[2:0];
            for (int i = 0; i < 3; i++) begin
                r_a[i] <= signed'(s_axis_tdata[3 + 16*i +: SB]);
                r_g[i] <= signed'(s_axis_tdata[51 + 16*i +: SB]);
            end
        end
        r_prod <= op_a * op_b;
        if (r_state == ssmvc_pkg::S_ACC) begin
            if (r_idx < 4'd3)      r_asq <= r_asq + r_prod[SQW-1:0];
            else if (r_idx < 4'd6) r_gsq <= r_gsq + r_prod[SQW-1:0];
            else if (r_idx == 4'd6) r_lg <= r_prod[31:0];
            else if (r_idx == 4'd7) r_lmin <= r_prod[31:0];
            else                    r_lmax <= r_prod[31:0];
        end else if (r_state == ssmvc_pkg::S_DECODE) begin
            r_asq <= '0;
            r_gsq <= '0;
        end
        if (r_state == ssmvc_pkg::S_ASTART) begin
            r_d <= d_now;
        end else if (r_state == ssmvc_pkg::S_MSTART) begin
            r_d <= diff_now;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_idx        <= '0;
            r_armed      <= 1'b0;
            r_armed_face <= ssmvc_pkg::FACE_IDLE;
            r_accepted   <= '0;
            r_rejected   <= '0;
            r_run        <= '0;
            r_magmean    <= '0;
            r_ok         <= 1'b0;
            for (int i = 0; i < 3; i++) begin
                r_mean[i] <= '0;
                r_m2[i]   <= '0;
                r_var[i]  <= '0;
            end
        end else begin
            case (r_state)
                ssmvc_pkg::S_IDLE: begin
                    if (s_acc) begin
                        r_ok  <= 1'b0;
                        r_idx <= '0;
                        for (int i = 0; i < 3; i++) r_var[i] <= '0;
                    end
                end
                ssmvc_pkg::S_DECODE: begin
                    case (r_cmd)
                        ssmvc_pkg::CMD_BEGIN: begin
                            if (r_face_in <= ssmvc_pkg::FACE_LAST) begin
                                r_armed      <= 1'b1;
                                r_armed_face <= r_face_in;
                                r_rejected   <= '0;
                                r_accepted   <= '0;
                                r_run        <= '0;
                                r_magmean    <= '0;
                                for (int i = 0; i < 3; i++) begin
                                    r_mean[i] <= '0;
                                    r_m2[i]   <= '0;
                                end
                            end
                        end
                        ssmvc_pkg::CMD_CANCEL: begin
                            r_armed      <= 1'b0;
                            r_armed_face <= ssmvc_pkg::FACE_IDLE;
                        end
                        ssmvc_pkg::CMD_FINISH: begin
                            if (done_now && r_accepted < CB'(2)) begin
                                r_ok         <= (r_accepted != '0);
                                r_armed      <= 1'b0;
                                r_armed_face <= ssmvc_pkg::FACE_IDLE;
                            end
                        end
                        default: ;
                    endcase
                end
                ssmvc_pkg::S_ACC: begin
                    r_idx <= (r_idx == 4'd8) ? 4'd0 : r_idx + 1'b1;
                end
                ssmvc_pkg::S_CHECK: begin
                    if (pass) begin
                        r_run      <= '0;
                        r_accepted <= acc_inc;
                    end else begin
                        r_rejected <= rej_inc;
                        r_run      <= run_inc;
                        // Drop the accumulation on a long reject run.
                        if (run_clear) begin
                            r_accepted <= '0;
                            r_run      <= '0;
                            r_magmean  <= '0;
                            for (int i = 0; i < 3; i++) begin
                                r_mean[i] <= '0;
                                r_m2[i]   <= '0;
                            end
                        end
                    end
                end
                ssmvc_pkg::S_AWAIT: begin
                    if (div_done) begin
                        r_mean[ax] <= MW'(mean_sel + q_s);
                    end
                end
                ssmvc_pkg::S_AACC: begin
                    r_m2[ax] <= (m2_sum > SUMW'({ssmvc_pkg::M2_W{1'b1}})) ?
                                '1 : m2_sum[ssmvc_pkg::M2_W-1:0];
                    r_idx    <= (r_idx == 4'd2) ? 4'd0 : r_idx + 1'b1;
                end
                ssmvc_pkg::S_MWAIT: begin
                    if (div_done) begin
                        r_magmean <= RW'(DW'({1'b0, r_magmean}) + q_s);
                        r_ok      <= 1'b1;
                    end
                end
                ssmvc_pkg::S_VWAIT: begin
                    if (div_done) begin
                        r_var[ax] <= (div_q[DVD_W-1:ssmvc_pkg::VAR_SHIFT+32] != '0) ?
                                     32'hFFFF_FFFF :
                                     div_q[ssmvc_pkg::VAR_SHIFT +: 32];
                        r_idx     <= r_idx + 1'b1;
                        if (r_idx == 4'd2) begin
                            r_ok         <= 1'b1;
                            r_armed      <= 1'b0;
                            r_armed_face <= ssmvc_pkg::FACE_IDLE;
                        end
                    end
                end
                default: ;
            endcase
        end
    end

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            mx[i] = 64'(r_mean[i]);
        end
        mag64 = 64'(r_magmean);
        acc64 = 64'(r_accepted);
        rej64 = 64'(r_rejected);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mvalid <= 1'b0;
        end else if (r_state == ssmvc_pkg::S_OUT && out_free) begin
            r_mvalid <= 1'b1;
        end else if (m_axis_tready) begin
            r_mvalid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == ssmvc_pkg::S_OUT && out_free) begin
            r_mdata <= {3'b000,
                        (rej64 > 64'hFFFF) ? 16'hFFFF : rej64[15:0],
                        (acc64 > 64'hFFFF) ? 16'hFFFF : acc64[15:0],
                        mag64[21:0],
                        r_var[2], r_var[1], r_var[0],
                        mx[2][21:0], mx[1][21:0], mx[0][21:0],
                        r_armed ? r_armed_face : ssmvc_pkg::FACE_IDLE,
                        done_now, r_ok};
        end
    end

    assign m_axis_tvalid = r_mvalid;
    assign m_axis_tdata  = r_mdata;

    ssmvc_div #(
        .DVS_W(CB)
    ) u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_req      (div_req),
        .i_dividend (div_dvd),
        .i_divisor  (div_dvs),
        .o_done     (div_done),
        .o_quot     (div_q)
    );

    ssmvc_sqrt #(
        .VW(VW)
    ) u_sqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (sqrt_start),
        .i_value ({r_asq, {ssmvc_pkg::MAG_SHIFT{1'b0}}}),
        .o_busy  (sqrt_busy),
        .o_root  (sqrt_root)
    );

    a_empty_accum: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_accepted == '0) |-> (r_magmean == '0 && r_m2[0] == '0 &&
                                r_m2[1] == '0 && r_m2[2] == '0))
        else $error("accumulation not empty with zero accepted samples");

    a_done_armed: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && m_axis_tdata[1]) |-> (m_axis_tdata[4:2] != ssmvc_pkg::FACE_IDLE))
        else $error("capture done reported while idle");

    a_var_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && (m_axis_tdata[102:71] != '0 || m_axis_tdata[134:103] != '0))
        |-> m_axis_tdata[0])
        else $error("variance output without successful finish");

    a_div_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ssmvc_pkg::S_IDLE) |-> !div_done)
        else $error("divider finished outside a transaction");

endmodule

`default_nettype wire

// ===== bench/tb_top.sv =====
// Self-checking bench for the still-sample mean/variance capture block.
// Drives command/sample transactions, predicts every result transaction
// with an independent model of the capture logic. Depends on ssmvc_pkg.
`timescale 1ns / 100ps

typedef struct packed {
    logic [2:0]  pad;
    logic [15:0] rejected_count;
    logic [15:0] accepted_count;
    logic [21:0] mean_magnitude;
    logic [31:0] var_z;
    logic [31:0] var_y;
    logic [31:0] var_x;
    logic [21:0] mean_z;
    logic [21:0] mean_y;
    logic [21:0] mean_x;
    logic [2:0]  face_out;
    logic        capture_done;
    logic        ok;
} t_capture_result;

class capture_scoreboard;
    localparam longint unsigned CNT_SAT = 64'hFFFF;
    localparam longint unsigned M2_SAT  = (64'd1 << 48) - 1;

    logic [15:0]       regs [5];
    bit                armed;
    logic [2:0]        face;
    longint unsigned   n_acc, n_rej, run_len;
    longint            axis_mean [3];
    longint unsigned   axis_m2 [3];
    longint            mag_mean;
    t_capture_result   pending_results [$];
    int                errors;
    int                checked;
    int                finishes_ok;

    function void reset_state();
        regs[ssmvc_pkg::REG_MAX_GYRO]  = 16'd80;
        regs[ssmvc_pkg::REG_MIN_ACCEL] = 16'd1843;
        regs[ssmvc_pkg::REG_MAX_ACCEL] = 16'd2253;
        regs[ssmvc_pkg::REG_RUN_LIMIT] = 16'd10;
        regs[ssmvc_pkg::REG_REQUIRED]  = 16'd200;
        armed = 0;
        face  = ssmvc_pkg::FACE_IDLE;
        n_rej = 0;
        clear_accum();
    endfunction

    function void clear_accum();
        n_acc = 0;
        run_len = 0;
        mag_mean = 0;
        for (int i = 0; i < 3; i++) begin
            axis_mean[i] = 0;
            axis_m2[i] = 0;
        end
    endfunction

    function void write_reg(logic [2:0] idx, logic [15:0] val);
        if (idx <= ssmvc_pkg::REG_REQUIRED) regs[idx] = val;
    endfunction

    function longint unsigned int_sqrt(longint unsigned v);
        longint unsigned r, bitv;
        r = 0;
        bitv = 64'd1 << 62;
        while (bitv > v) bitv >>= 2;
        while (bitv != 0) begin
            if (v >= r + bitv) begin
                v -= r + bitv;
                r = (r >> 1) + bitv;
            end else begin
                r >>= 1;
            end
            bitv >>= 2;
        end
        return r;
    endfunction

    function bit is_done();
        return armed && (n_acc >= longint'(regs[ssmvc_pkg::REG_REQUIRED]));
    endfunction

    function bit take_sample(logic [103:0] d);
        longint a [3];
        longint g [3];
        longint unsigned asq, gsq, lg, lmin, lmax, mag, p;
        longint n, x, dl, d2;
        asq = 0;
        gsq = 0;
        for (int i = 0; i < 3; i++) begin
            a[i] = longint'($signed(d[3 + 16*i +: 16]));
            g[i] = longint'($signed(d[51 + 16*i +: 16]));
            asq += longint'(a[i] * a[i]);
            gsq += longint'(g[i] * g[i]);
        end
        lg = regs[ssmvc_pkg::REG_MAX_GYRO];
        lmin = regs[ssmvc_pkg::REG_MIN_ACCEL];
        lmax = regs[ssmvc_pkg::REG_MAX_ACCEL];
        if (!(gsq <= lg*lg && asq >= lmin*lmin && asq <= lmax*lmax)) begin
            n_rej = (n_rej < CNT_SAT) ? n_rej + 1 : CNT_SAT;
            run_len = (run_len < CNT_SAT) ? run_len + 1 : CNT_SAT;
            if (regs[ssmvc_pkg::REG_RUN_LIMIT] != 0 && n_acc > 0 &&
                run_len >= regs[ssmvc_pkg::REG_RUN_LIMIT])
                clear_accum();
            return 0;
        end
        run_len = 0;
        n_acc = (n_acc < CNT_SAT) ? n_acc + 1 : CNT_SAT;
        n = longint'(n_acc);
        mag = int_sqrt(asq << 10);
        for (int i = 0; i < 3; i++) begin
            x = a[i] * 32;
            dl = x - axis_mean[i];
            axis_mean[i] += dl / n;
            d2 = x - axis_mean[i];
            p = longint'(dl * d2);
            axis_m2[i] = (p > M2_SAT - axis_m2[i]) ? M2_SAT : axis_m2[i] + p;
        end
        mag_mean += (longint'(mag) - mag_mean) / n;
        return 1;
    endfunction

    function void note_input(logic [1:0] cmd, logic [103:0] d);
        t_capture_result r;
        longint unsigned v;
        logic [31:0] vars [3];
        bit ok;
        ok = 0;
        for (int i = 0; i < 3; i++) vars[i] = 0;
        case (cmd)
            ssmvc_pkg::CMD_SAMPLE: if (armed) ok = take_sample(d);
            ssmvc_pkg::CMD_BEGIN: begin
                if (d[2:0] <= ssmvc_pkg::FACE_LAST) begin
                    armed = 1;
                    face = d[2:0];
                    n_rej = 0;
                    clear_accum();
                end
            end
            ssmvc_pkg::CMD_CANCEL: begin
                armed = 0;
                face = ssmvc_pkg::FACE_IDLE;
            end
            default: begin
                if (is_done()) begin
                    if (n_acc >= 2) begin
                        for (int i = 0; i < 3; i++) begin
                            v = (axis_m2[i] / (n_acc - 1)) >> 10;
                            vars[i] = (v > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : v[31:0];
                        end
                    end
                    ok = n_acc > 0;
                    if (ok) finishes_ok++;
                    armed = 0;
                    face = ssmvc_pkg::FACE_IDLE;
                end
            end
        endcase
        r.pad = 0;
        r.ok = ok;
        r.capture_done = is_done();
        r.face_out = armed ? face : ssmvc_pkg::FACE_IDLE;
        r.mean_x = axis_mean[0][21:0];
        r.mean_y = axis_mean[1][21:0];
        r.mean_z = axis_mean[2][21:0];
        r.var_x = vars[0];
        r.var_y = vars[1];
        r.var_z = vars[2];
        r.mean_magnitude = mag_mean[21:0];
        r.accepted_count = n_acc[15:0];
        r.rejected_count = n_rej[15:0];
        pending_results.push_back(r);
    endfunction

    function void cmp(string name, longint unsigned want, longint unsigned got);
        if (want != got) begin
            errors++;
            $display("%0t mismatch %s: expected %0h actual %0h", $time, name, want, got);
        end
    endfunction

    function void check_result(logic [223:0] d);
        t_capture_result w, a;
        a = d;
        if (pending_results.size() == 0) begin
            errors++;
            $display("%0t unexpected result transaction: expected none actual %h",
                     $time, d);
            return;
        end
        w = pending_results.pop_front();
        checked++;
        cmp("ok", w.ok, a.ok);
        cmp("capture_done", w.capture_done, a.capture_done);
        cmp("face_out", w.face_out, a.face_out);
        cmp("mean_x", w.mean_x, a.mean_x);
        cmp("mean_y", w.mean_y, a.mean_y);
        cmp("mean_z", w.mean_z, a.mean_z);
        cmp("var_x", w.var_x, a.var_x);
        cmp("var_y", w.var_y, a.var_y);
        cmp("var_z", w.var_z, a.var_z);
        cmp("mean_magnitude", w.mean_magnitude, a.mean_magnitude);
        cmp("accepted_count", w.accepted_count, a.accepted_count);
        cmp("rejected_count", w.rejected_count, a.rejected_count);
        cmp("pad", 0, a.pad);
    endfunction
endclass

module tb_top;
    localparam int STALL_LIMIT = 5000;

    logic          i_clk;
    logic          i_rst_n;
    logic          i_cfg_wr_en;
    logic [2:0]    i_cfg_index;
    logic [15:0]   i_cfg_wdata;
    logic          s_axis_tvalid;
    logic          s_axis_tready;
    logic [103:0]  s_axis_tdata;   // face, accel x/y/z, gyro x/y/z, zero pad
    logic [1:0]    s_axis_tuser;   // cmd
    logic          m_axis_tvalid;
    logic          m_axis_tready;
    logic [223:0]  m_axis_tdata;   // ok, done, face, means, vars, magnitude, counts

    capture_scoreboard sb;
    int  tx_idle;
    int  rx_idle;
    int  rx_hold;
    int  items_sent;
    int  quiet_cycles;

    still_sample_mean_variance_capture DUT (
        .i_clk(i_clk),
        .i_rst_n(i_rst_n),
        .i_cfg_wr_en(i_cfg_wr_en),
        .i_cfg_index(i_cfg_index),
        .i_cfg_wdata(i_cfg_wdata),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata),
        .s_axis_tuser(s_axis_tuser),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata)
    );

    initial begin
        i_clk = 0;
        forever #5 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        if (i_rst_n && s_axis_tvalid && s_axis_tready)
            sb.note_input(s_axis_tuser, s_axis_tdata);
        if (i_rst_n && m_axis_tvalid && m_axis_tready)
            sb.check_result(m_axis_tdata);
    end

    // Receiver: random back-pressure, plus a long hold-off on request
    always @(negedge i_clk) begin
        if (rx_hold > 0) begin
            m_axis_tready <= 1'b0;
            rx_hold <= rx_hold - 1;
        end else begin
            m_axis_tready <= ($urandom_range(99) >= rx_idle);
        end
    end

    always @(posedge i_clk) begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= STALL_LIMIT) begin
            $display("%0t watchdog: no transaction for %0d cycles", $time, STALL_LIMIT);
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    function automatic logic [103:0] pack_item(logic [2:0] f, logic [15:0] ax,
            logic [15:0] ay, logic [15:0] az, logic [15:0] gx, logic [15:0] gy,
            logic [15:0] gz);
        return {5'b0, gz, gy, gx, az, ay, ax, f};
    endfunction

    function automatic logic [103:0] noise_item();
        logic [127:0] r;
        r = {$urandom, $urandom, $urandom, $urandom};
        return {5'b0, r[98:0]};
    endfunction

    // Still sample near 1 g on a random axis, small gyro
    function automatic logic [103:0] still_item();
        logic [15:0] ax [3];
        logic [15:0] gy [3];
        int big;
        big = $urandom_range(2);
        for (int i = 0; i < 3; i++) begin
            ax[i] = 16'($signed($urandom_range(300)) - 150);
            gy[i] = ($urandom_range(9) < 3) ? 16'd0 : 16'($signed($urandom_range(60)) - 30);
        end
        ax[big] = 16'(1898 + $urandom_range(300));
        if ($urandom_range(1)) ax[big] = -ax[big];
        return pack_item(3'($urandom), ax[0], ax[1], ax[2], gy[0], gy[1], gy[2]);
    endfunction

    // Entered and left at a falling edge
    task automatic send_item(logic [1:0] cmd, logic [103:0] d);
        while ($urandom_range(99) < tx_idle) begin
            s_axis_tvalid <= 1'b0;
            @(negedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser <= cmd;
        s_axis_tdata <= d;
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        items_sent++;
        @(negedge i_clk);
    endtask

    task automatic drain();
        s_axis_tvalid <= 1'b0;
        while (sb.pending_results.size() != 0) @(posedge i_clk);
        repeat (8) @(negedge i_clk);
    endtask

    task automatic configure(logic [15:0] gyro, logic [15:0] amin, logic [15:0] amax,
            logic [15:0] run_limit, logic [15:0] required);
        logic [15:0] vals [5];
        vals = '{gyro, amin, amax, run_limit, required};
        for (int i = 0; i < 5; i++) begin
            i_cfg_wr_en <= 1'b1;
            i_cfg_index <= 3'(i);
            i_cfg_wdata <= vals[i];
            @(posedge i_clk);
            sb.write_reg(3'(i), vals[i]);
            @(negedge i_clk);
        end
        i_cfg_wr_en <= 1'b0;
    endtask

    task automatic sample(logic [103:0] d);
        send_item(ssmvc_pkg::CMD_SAMPLE, d);
    endtask

    task automatic face_cmd(logic [1:0] cmd, logic [2:0] f);
        send_item(cmd, pack_item(f, 16'($urandom), 16'($urandom), 16'($urandom),
                                 16'($urandom), 16'($urandom), 16'($urandom)));
    endtask

    // Mostly well-formed capture sessions with some noise and broken ones
    task automatic random_sessions(int n_items, int max_samples);
        int stop_at, k;
        stop_at = items_sent + n_items;
        while (items_sent < stop_at) begin
            if ($urandom_range(99) < 8) begin
                send_item(2'($urandom), noise_item());
            end else begin
                face_cmd(ssmvc_pkg::CMD_BEGIN,
                         ($urandom_range(9) == 0) ? 3'(6 + $urandom_range(1))
                                                  : 3'($urandom_range(5)));
                k = $urandom_range(max_samples);
                for (int i = 0; i < k; i++)
                    sample(($urandom_range(99) < 80) ? still_item() : noise_item());
                if ($urandom_range(9) == 0)
                    face_cmd(ssmvc_pkg::CMD_CANCEL, 3'($urandom));
                face_cmd(ssmvc_pkg::CMD_FINISH, 3'($urandom));
                if ($urandom_range(9) == 0)
                    face_cmd(ssmvc_pkg::CMD_FINISH, 3'($urandom));
            end
        end
    endtask

    initial begin
        sb = new();
        sb.reset_state();
        tx_idle = 10;
        rx_idle = 10;
        rx_hold = 0;
        items_sent = 0;
        quiet_cycles = 0;
        i_rst_n = 1'b0;
        i_cfg_wr_en = 1'b0;
        i_cfg_index = '0;
        i_cfg_wdata = '0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata = '0;
        s_axis_tuser = ssmvc_pkg::CMD_SAMPLE;
        m_axis_tready = 1'b0;
        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // Directed: idle commands, bad faces, rejects, reject-run clear, re-arm
        configure(16'd80, 16'd1843, 16'd2253, 16'd2, 16'd2);
        face_cmd(ssmvc_pkg::CMD_FINISH, 3'd0);
        sample(still_item());
        face_cmd(ssmvc_pkg::CMD_BEGIN, 3'd6);
        face_cmd(ssmvc_pkg::CMD_BEGIN, 3'd7);
        face_cmd(ssmvc_pkg::CMD_BEGIN, 3'd0);
        sample(still_item());
        face_cmd(ssmvc_pkg::CMD_FINISH, 3'd0);
        sample(pack_item(3'd0, 16'd0, 16'd0, 16'd2048, 16'h7FFF, 16'h8000, 16'h7FFF));
        sample(pack_item(3'd0, 16'h7FFF, 16'h8000, 16'h8000, 16'd0, 16'd0, 16'd0));
        sample(still_item());
        face_cmd(ssmvc_pkg::CMD_BEGIN, 3'd5);
        sample(still_item());
        sample(noise_item());
        sample(pack_item(3'd7, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0));
        sample(still_item());
        sample(still_item());
        sample(still_item());
        face_cmd(ssmvc_pkg::CMD_FINISH, 3'd0);
        face_cmd(ssmvc_pkg::CMD_BEGIN, 3'd3);
        sample(still_item());
        face_cmd(ssmvc_pkg::CMD_CANCEL, 3'd0);
        face_cmd(ssmvc_pkg::CMD_FINISH, 3'd0);
        drain();

        configure(16'd80, 16'd1843, 16'd2253, 16'd3, 16'($urandom_range(1, 8)));
        rx_hold = 600;
        random_sessions(180, 12);
        drain();

        // Wide-open limits: every sample passes
        configure(16'hFFFF, 16'd0, 16'hFFFF, 16'd0, 16'd5);
        random_sessions(160, 8);
        drain();

        configure(16'd0, 16'd1843, 16'd2253, 16'hFFFF, 16'd1);
        random_sessions(140, 6);
        drain();

        configure(16'd80, 16'hFFFF, 16'd2253, 16'd1, 16'hFFFF);
        random_sessions(100, 6);
        drain();

        // No idling on either side here
        tx_idle = 0;
        rx_idle = 0;
        configure(16'd80, 16'd1843, 16'd2253, 16'd10, 16'd12);
        random_sessions(270, 16);
        tx_idle = 10;
        rx_idle = 10;
        drain();
        repeat (200) @(posedge i_clk);

        $display("Sent %0d transactions, checked %0d results, %0d completed finishes",
                 items_sent, sb.checked, sb.finishes_ok);
        $display("over six limit settings including the register extremes.");
        if (sb.errors == 0 && sb.pending_results.size() == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end
endmodule

// ===== filelist.f =====
hw/rtl/ssmvc_pkg.sv
hw/rtl/ssmvc_div.sv
hw/rtl/ssmvc_sqrt.sv
hw/rtl/still_sample_mean_variance_capture.sv
bench/tb_top.sv
